FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/stpc_pkg.sv
// Shared types and constants of the stick to paddle conditioner.
`default_nettype none
package stpc_pkg;
	localparam int CFG_DATA_W = 16;
	localparam int DZ_W       = 16;
	localparam int PADDLE_W   = 8;
	localparam int ROOT_GUARD = 8;
	localparam logic [PADDLE_W-1:0] CENTRE = 8'd128;
	localparam logic [PADDLE_W-1:0] PADDLE_MAX = 8'd255;

	typedef enum logic [1:0] {
		CFG_INVERT_X    = 2'd0,
		CFG_INVERT_Y    = 2'd1,
		CFG_DEADZONE    = 2'd2,
		CFG_SQUARE_GATE = 2'd3
	} cfg_reg_t;
endpackage
`default_nettype wire

FILE: hw/rtl/stpc_if.sv
// Valid/ready channels for stick samples and paddle values.
`default_nettype none
interface stpc_in_if #(parameter int AXIS_BITS = 16) ();
	logic                        valid;
	logic                        ready;
	logic signed [AXIS_BITS-1:0] stick_x;
	logic signed [AXIS_BITS-1:0] stick_y;
	logic                        device_present;
	logic [1:0]                  paddle_index;
	modport source (output valid, stick_x, stick_y, device_present, paddle_index, input ready);
	modport sink (input valid, stick_x, stick_y, device_present, paddle_index, output ready);
endinterface

interface stpc_out_if import stpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PADDLE_W-1:0] paddle_value;
	modport source (output valid, paddle_value, input ready);
	modport sink (input valid, paddle_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stpc_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module stpc_isqrt #(
	parameter int ROOT_W = 24,
	parameter int SIDE_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic [2*ROOT_W-1:0]   rad,
	input  wire logic [SIDE_W-1:0]     side_in,
	output logic                       out_valid,
	output logic [ROOT_W-1:0]          root,
	output logic [SIDE_W-1:0]          side_out
);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              v_s    [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];

	logic [RAD_W-1:0]  rad_nx  [ROOT_W];
	logic [REM_W-1:0]  rem_nx  [ROOT_W];
	logic [ROOT_W-1:0] root_nx [ROOT_W];

	always_comb begin
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [REM_W-1:0]  rem_t;
		logic [REM_W-1:0]  trial;
		logic [ROOT_W-1:0] root_i;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				rad_i  = rad;
				rem_i  = '0;
				root_i = '0;
			end else begin
				rad_i  = rad_s[k-1];
				rem_i  = rem_s[k-1];
				root_i = root_s[k-1];
			end
			// bring down the next pair of radicand bits
			rem_t = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
			trial = {root_i, 2'b01};
			if (rem_t >= trial) begin
				rem_nx[k]  = rem_t - trial;
				root_nx[k] = {root_i[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = rem_t;
				root_nx[k] = {root_i[ROOT_W-2:0], 1'b0};
			end
			rad_nx[k] = rad_i << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < ROOT_W; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				rad_s[k]  <= rad_nx[k];
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
			end
			side_s[0] <= side_in;
			for (int k = 1; k < ROOT_W; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign side_out  = side_s[ROOT_W-1];
endmodule
`default_nettype wire

FILE: hw/rtl/stpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module stpc_div #(
	parameter int NUM_W  = 40,
	parameter int DEN_W  = 24,
	parameter int Q_W    = 17,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quo,
	output logic [SIDE_W-1:0]      side_out
);
	localparam int REM_W = DEN_W + 1;
	localparam int HI_W  = NUM_W - Q_W;

	logic              v_s    [Q_W];
	logic [REM_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    low_s  [Q_W];
	logic [Q_W-1:0]    q_s    [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	logic [REM_W-1:0] rem_nx [Q_W];
	logic [Q_W-1:0]   low_nx [Q_W];
	logic [Q_W-1:0]   q_nx   [Q_W];

	// The quotient is known to fit Q_W bits, so the high part starts below den.
	always_comb begin
		logic [REM_W-1:0] rem_i;
		logic [REM_W-1:0] rem_t;
		logic [Q_W-1:0]   low_i;
		logic [Q_W-1:0]   q_i;
		logic [DEN_W-1:0] den_i;
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				rem_i = REM_W'(num[NUM_W-1 -: HI_W]);
				low_i = num[Q_W-1:0];
				q_i   = '0;
				den_i = den;
			end else begin
				rem_i = rem_s[k-1];
				low_i = low_s[k-1];
				q_i   = q_s[k-1];
				den_i = den_s[k-1];
			end
			rem_t = {rem_i[REM_W-2:0], low_i[Q_W-1]};
			if (rem_t >= {1'b0, den_i}) begin
				rem_nx[k] = rem_t - {1'b0, den_i};
				q_nx[k]   = {q_i[Q_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = rem_t;
				q_nx[k]   = {q_i[Q_W-2:0], 1'b0};
			end
			low_nx[k] = low_i << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Q_W; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < Q_W; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k] <= rem_nx[k];
				low_s[k] <= low_nx[k];
				q_s[k]   <= q_nx[k];
			end
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int k = 1; k < Q_W; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = q_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];
endmodule
`default_nettype wire

FILE: hw/rtl/stick_to_paddle_conditioner.sv
// Top level: stick sample to paddle value, fully pipelined.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | stick_x, stick_y, device_present, paddle_index
//  out_ch   | out | valid/ready   | paddle_value
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One item per cycle while the output is taken or empty; the pipe holds the
// bit-serial root stages (AXIS_BITS+8) and divider stages (AXIS_BITS+1).
// arst_n clears all valid bits and the configuration registers.
// A held output stalls every stage at once; nothing is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"
module stick_to_paddle_conditioner import stpc_pkg::*; #(
	parameter int AXIS_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cfg_reg_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	stpc_in_if.sink                    in_ch,
	stpc_out_if.source                 out_ch
);
	localparam int A        = AXIS_BITS;
	localparam int SCALE_I  = 1 << (A - 1);
	localparam int GATE_MIN = SCALE_I / 10000;
	localparam int SQ_W     = 2 * A;
	localparam int ROOT_W   = A + ROOT_GUARD;
	localparam int NUM_W    = A + ROOT_W;
	localparam int DEN_W    = A + ROOT_GUARD;
	localparam int Q_W      = A + 1;
	localparam int CMP_W    = (SQ_W > 2 * DZ_W) ? SQ_W : 2 * DZ_W;
	localparam int RS_W     = 3 * A + 5;
	localparam int DS_W     = A + 5;
	localparam int MAP_W    = A + 9;

	// configuration
	logic              inv_x_q, inv_y_q, gate_en_q;
	logic [DZ_W-1:0]   dz_q;
	logic [2*DZ_W-1:0] dz_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q   <= 1'b0;
			inv_y_q   <= 1'b0;
			gate_en_q <= 1'b0;
			dz_q      <= '0;
			dz_sq_q   <= '0;
		end else begin
			dz_sq_q <= dz_q * dz_q;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INVERT_X:    inv_x_q   <= cfg_data[0];
					CFG_INVERT_Y:    inv_y_q   <= cfg_data[0];
					CFG_DEADZONE:    dz_q      <= cfg_data[DZ_W-1:0];
					CFG_SQUARE_GATE: gate_en_q <= cfg_data[0];
					default:         ;
				endcase
			end
		end
	end

	logic en;
	logic out_v_q;
	logic [PADDLE_W-1:0] paddle_q;

	// advance the whole pipe unless the output register holds an untaken item
	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: sign extend and invert
	logic              v_s1, pass_s1, sel_s1;
	logic signed [A:0] x_s1, y_s1;
	logic signed [A:0] xe, ye;

	assign xe = {in_ch.stick_x[A-1], in_ch.stick_x};
	assign ye = {in_ch.stick_y[A-1], in_ch.stick_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= inv_x_q ? -xe : xe;
			y_s1    <= inv_y_q ? -ye : ye;
			pass_s1 <= in_ch.device_present && !in_ch.paddle_index[1];
			sel_s1  <= in_ch.paddle_index[0];
		end
	end

	// stage 2: magnitudes, squared length, chosen component
	logic [A:0]   nx, ny;
	logic [A-1:0] ax, ay;
	logic              v_s2, pass_s2, cneg_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [A-1:0]      cabs_s2, m_s2;
	logic signed [A:0] c_s2;

	assign nx = -x_s1;
	assign ny = -y_s1;
	assign ax = x_s1[A] ? nx[A-1:0] : x_s1[A-1:0];
	assign ay = y_s1[A] ? ny[A-1:0] : y_s1[A-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2   <= SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
			m_s2    <= (ax > ay) ? ax : ay;
			cabs_s2 <= sel_s1 ? ay : ax;
			cneg_s2 <= sel_s1 ? y_s1[A] : x_s1[A];
			c_s2    <= sel_s1 ? y_s1 : x_s1;
			pass_s2 <= pass_s1;
		end
	end

	// stage 3: deadzone and gate decision
	logic              v_s3, pass_s3, zero_s3, gate_s3, cneg_s3;
	logic [SQ_W-1:0]   sq_s3;
	logic [A-1:0]      cabs_s3, m_s3;
	logic signed [A:0] c_s3;
	logic              zero_c;

	assign zero_c = CMP_W'(sq_s2) < CMP_W'(dz_sq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= sq_s2;
			zero_s3 <= zero_c;
			gate_s3 <= gate_en_q && !zero_c && (m_s2 > A'(GATE_MIN));
			cabs_s3 <= cabs_s2;
			m_s3    <= m_s2;
			cneg_s3 <= cneg_s2;
			c_s3    <= c_s2;
			pass_s3 <= pass_s2;
		end
	end

	// root stages: mag8 = floor(sqrt(sq << 16))
	logic              rt_v;
	logic [ROOT_W-1:0] rt_root;
	logic [RS_W-1:0]   rt_side;

	stpc_isqrt #(.ROOT_W(ROOT_W), .SIDE_W(RS_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.rad      ({sq_s3, {(2*ROOT_GUARD){1'b0}}}),
		.side_in  ({pass_s3, zero_s3, gate_s3, cneg_s3, cabs_s3, m_s3, c_s3}),
		.out_valid(rt_v),
		.root     (rt_root),
		.side_out (rt_side)
	);

	logic              rt_pass, rt_zero, rt_gate, rt_cneg;
	logic [A-1:0]      rt_cabs, rt_m;
	logic signed [A:0] rt_c;

	assign {rt_pass, rt_zero, rt_gate, rt_cneg, rt_cabs, rt_m, rt_c} = rt_side;

	// multiply stage: |c| * mag8 plus half the divisor for rounding
	logic              v_sm;
	logic [NUM_W-1:0]  num_sm;
	logic [DEN_W-1:0]  den_sm;
	logic [DS_W-1:0]   side_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else if (en) v_sm <= rt_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sm  <= NUM_W'(rt_cabs) * NUM_W'(rt_root)
				+ NUM_W'({rt_m, {(ROOT_GUARD-1){1'b0}}});
			den_sm  <= {rt_m, {ROOT_GUARD{1'b0}}};
			side_sm <= {rt_pass, rt_zero, rt_gate, rt_cneg, rt_c};
		end
	end

	logic            dv_v;
	logic [Q_W-1:0]  dv_q;
	logic [DS_W-1:0] dv_side;

	stpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .SIDE_W(DS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_sm),
		.num      (num_sm),
		.den      (den_sm),
		.side_in  (side_sm),
		.out_valid(dv_v),
		.quo      (dv_q),
		.side_out (dv_side)
	);

	// output stage: saturate, pick component, map to 0..255
	logic              dv_pass, dv_zero, dv_gate, dv_cneg;
	logic signed [A:0] dv_c;
	logic [A:0]        sat_a, q_u, u;
	logic [MAP_W-1:0]  mapped;
	logic [PADDLE_W-1:0] paddle_c;

	assign {dv_pass, dv_zero, dv_gate, dv_cneg, dv_c} = dv_side;

	always_comb begin
		sat_a = (dv_q > Q_W'(SCALE_I)) ? (A+1)'(SCALE_I) : dv_q;
		if (dv_zero)      q_u = '0;
		else if (dv_gate) q_u = dv_cneg ? -sat_a : sat_a;
		else              q_u = dv_c;
		u      = q_u + (A+1)'(SCALE_I);
		mapped = MAP_W'(u) * MAP_W'(255) + MAP_W'(SCALE_I);
		if (!dv_pass)                  paddle_c = CENTRE;
		else if (mapped[MAP_W-1 -: 1]) paddle_c = PADDLE_MAX;
		else                           paddle_c = mapped[A +: PADDLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (en) paddle_q <= paddle_c;
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.paddle_value = paddle_q;

	`ASSERT_AT(a_stall_blocks_input, clk, arst_n, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready, "input taken while output stalled")
	`ASSERT_NEVER(a_ready_without_hold, clk, arst_n, !in_ch.ready && !out_ch.valid, "input held off with empty output")
endmodule
`default_nettype wire
